// ===== hdl/sor_pkg.sv =====
// shared types and constants for the symmetry orbit representative core
`default_nettype none

package sor_pkg;

  localparam int STATE_W = 32;
  localparam int PERM_W  = 6;
  localparam int SITE_W  = 5;
  localparam int MASK_W  = 64;
  localparam int CNT_W   = 7;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 64;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } sor_cmd_t;

  typedef enum logic [1:0] {
    REG_SYM_COUNT   = 2'd0,
    REG_USE_SUBSET  = 2'd1,
    REG_SUBSET_MASK = 2'd2
  } sor_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  sym_count;
    logic              use_subset;
    logic [MASK_W-1:0] subset_mask;
  } sor_cfg_t;

  // one item travelling down the chain, with the running search result
  typedef struct packed {
    logic               valid;
    logic               command;
    logic [PERM_W-1:0]  perm_index;
    logic [SITE_W-1:0]  site_index;
    logic [SITE_W-1:0]  target_site;
    logic [STATE_W-1:0] state;
    logic               found;
    logic [STATE_W-1:0] best;
    logic [PERM_W-1:0]  best_perm;
    logic [MASK_W-1:0]  ties;
    logic [CNT_W-1:0]   tie_count;
  } sor_item_t;

endpackage

`default_nettype wire

// ===== hdl/sor_ifs.sv =====
// item and result channel interfaces
`default_nettype none

interface sor_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  perm_index;
  logic [4:0]  site_index;
  logic [4:0]  target_site;
  logic [31:0] state_bits;

  modport source (output valid, command, perm_index, site_index, target_site, state_bits,
                  input ready);
  modport sink (input valid, command, perm_index, site_index, target_site, state_bits,
                output ready);
endinterface

interface sor_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rep_state;
  logic [5:0]  rep_perm;
  logic [63:0] tie_mask;
  logic [6:0]  tie_count;
  logic        empty_search;

  modport source (output valid, rep_state, rep_perm, tie_mask, tie_count, empty_search,
                  input ready);
  modport sink (input valid, rep_state, rep_perm, tie_mask, tie_count, empty_search,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/sor_regs.sv =====
// apb configuration registers
`default_nettype none

module sor_regs
  import sor_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output sor_cfg_t               cfg
);

  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[APB_AW-1:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sym_count   <= CNT_W'(1);
      cfg.use_subset  <= 1'b0;
      cfg.subset_mask <= '1;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SYM_COUNT:   cfg.sym_count   <= pwdata[CNT_W-1:0];
        REG_USE_SUBSET:  cfg.use_subset  <= pwdata[0];
        REG_SUBSET_MASK: cfg.subset_mask <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SYM_COUNT:   prdata = APB_DW'(cfg.sym_count);
      REG_USE_SUBSET:  prdata = APB_DW'(cfg.use_subset);
      REG_SUBSET_MASK: prdata = APB_DW'(cfg.subset_mask);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sor_cell.sv =====
// one chain cell: holds one permutation and folds it into the running minimum
`default_nettype none

module sor_cell
  import sor_pkg::*;
#(
  parameter int SITES = 32,
  parameter int CELL  = 0
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      adv,
  input  wire sor_cfg_t  cfg,
  input  wire sor_item_t c_in,
  output sor_item_t      c_out
);

  localparam int LIVE = (SITES < STATE_W) ? SITES : STATE_W;
  localparam int IDX_W = $clog2(LIVE);
  localparam logic [SITE_W:0] LIVE_W = (SITE_W+1)'(LIVE);
  localparam logic [MASK_W-1:0] CELL_BIT = MASK_W'(1) << CELL;

  logic [SITE_W-1:0]  perm_tab [LIVE];
  logic [STATE_W-1:0] permuted;
  logic               searched;
  logic               tab_wr;
  sor_item_t          c_next;

  assign tab_wr = adv && c_in.valid && (c_in.command == CMD_WRITE)
               && (c_in.perm_index == PERM_W'(CELL))
               && ({1'b0, c_in.site_index} < LIVE_W);

  always_ff @(posedge clk) begin
    if (tab_wr) begin
      perm_tab[c_in.site_index[IDX_W-1:0]] <= c_in.target_site;
    end
  end

  // bit at site i lands on site perm_tab[i]
  always_comb begin
    permuted = '0;
    for (int i = 0; i < LIVE; i++) begin
      if (c_in.state[i] && ({1'b0, perm_tab[i]} < LIVE_W)) begin
        permuted[perm_tab[i]] = 1'b1;
      end
    end
  end

  assign searched = (CNT_W'(CELL) < cfg.sym_count)
                 && (!cfg.use_subset || cfg.subset_mask[CELL]);

  always_comb begin
    c_next = c_in;
    if (c_in.command == CMD_QUERY && searched) begin
      if (!c_in.found || permuted < c_in.best) begin
        c_next.found     = 1'b1;
        c_next.best      = permuted;
        c_next.best_perm = PERM_W'(CELL);
        c_next.ties      = CELL_BIT;
        c_next.tie_count = CNT_W'(1);
      end else if (permuted == c_in.best) begin
        c_next.ties      = c_in.ties | CELL_BIT;
        c_next.tie_count = c_in.tie_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_out.valid <= 1'b0;
    end else if (adv) begin
      c_out <= c_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/symmetry_orbit_representative_core.sv =====
// top level of the symmetry orbit representative core
//
// channel   dir  handshake    content
// item      in   valid/ready  table write or query state
// result    out  valid/ready  minimum state, index, tie mask and count
// apb       in   psel/penable sym_count, use_subset, subset_mask
//
// one cell per permutation; every item walks the chain one cell a cycle while not stalled
// one item accepted per cycle while the result is not stalled; the result is registered after the last cell
// table writes travel the chain in order with queries, so no draining is needed
// a stalled result freezes the whole chain and holds item ready low
// rst clears the valid bits and the registers; the table is undefined until written
`default_nettype none

module symmetry_orbit_representative_core
  import sor_pkg::*;
#(
  parameter int SITES     = 32,
  parameter int MAX_PERMS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  sor_in_if.sink                 item,
  sor_out_if.source              result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  sor_cfg_t  cfg;
  sor_item_t stage [MAX_PERMS+1];
  sor_item_t last;
  logic      adv;

  assign pready = 1'b1;

  sor_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;

  always_comb begin
    stage[0].valid       = item.valid && item.ready;
    stage[0].command     = item.command;
    stage[0].perm_index  = item.perm_index;
    stage[0].site_index  = item.site_index;
    stage[0].target_site = item.target_site;
    stage[0].state       = item.state_bits;
    stage[0].found       = 1'b0;
    stage[0].best        = '0;
    stage[0].best_perm   = '0;
    stage[0].ties        = '0;
    stage[0].tie_count   = '0;
  end

  for (genvar k = 0; k < MAX_PERMS; k++) begin : g_cell
    sor_cell #(
      .SITES (SITES),
      .CELL  (k)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .cfg   (cfg),
      .c_in  (stage[k]),
      .c_out (stage[k+1])
    );
  end

  assign last = stage[MAX_PERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= last.valid && (last.command == CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (last.found) begin
        result.rep_state    <= last.best;
        result.rep_perm     <= last.best_perm;
        result.tie_mask     <= last.ties;
        result.tie_count    <= last.tie_count;
        result.empty_search <= 1'b0;
      end else begin
        result.rep_state    <= last.state;
        result.rep_perm     <= '0;
        result.tie_mask     <= '0;
        result.tie_count    <= '0;
        result.empty_search <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.empty_search |-> result.tie_count == '0 && result.tie_mask == '0)
    else $error("empty search with ties");

  a_tie_count: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> 32'(result.tie_count) == $countones(result.tie_mask))
    else $error("tie count does not match tie mask");

  a_best_in_ties: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.empty_search |-> result.tie_mask[result.rep_perm])
    else $error("chosen permutation missing from tie mask");

  a_reset_count: assert property (@(posedge clk)
    $past(rst) |-> cfg.sym_count == CNT_W'(1) && !cfg.use_subset)
    else $error("configuration not at reset value");
`endif

endmodule

`default_nettype wire

// ===== tb/orbit_rep_checker.sv =====
// checker that predicts and compares the results of the symmetry orbit representative core
module orbit_rep_checker
  import sor_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sor_in_if                 item,
  sor_out_if                result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fails,
  output int                waiting,
  output int                checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SITES     = 32;
  localparam int MAX_PERMS = 64;

  typedef struct packed {
    logic [STATE_W-1:0] rep_state;
    logic [PERM_W-1:0]  rep_perm;
    logic [MASK_W-1:0]  tie_mask;
    logic [CNT_W-1:0]   tie_count;
    logic               empty_search;
  } orbit_rep_t;

  logic [SITE_W-1:0] site_map [MAX_PERMS][SITES];
  logic [CNT_W-1:0]  cfg_count;
  logic              cfg_subset;
  logic [MASK_W-1:0] cfg_mask;
  orbit_rep_t        reps_due [$];
  int                reported;

  function automatic orbit_rep_t reduce_orbit(input logic [STATE_W-1:0] st);
    orbit_rep_t        r;
    logic [STATE_W-1:0] img;
    int                n, k, i;
    n = (cfg_count > MAX_PERMS) ? MAX_PERMS : int'(cfg_count);
    r = '{rep_state: st, rep_perm: '0, tie_mask: '0, tie_count: '0, empty_search: 1'b1};
    for (k = 0; k < n; k++) begin
      if (cfg_subset && !cfg_mask[k]) continue;
      img = '0;
      for (i = 0; i < SITES; i++) begin
        if (st[i]) img[site_map[k][i]] = 1'b1;
      end
      if (r.empty_search || img < r.rep_state) begin
        r.empty_search = 1'b0;
        r.rep_state    = img;
        r.rep_perm     = PERM_W'(k);
        r.tie_mask     = '0;
        r.tie_mask[k]  = 1'b1;
        r.tie_count    = CNT_W'(1);
      end else if (img == r.rep_state) begin
        r.tie_mask[k] = 1'b1;
        r.tie_count   = r.tie_count + 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    orbit_rep_t want, got;
    if (rst) begin
      cfg_count  = CNT_W'(1);
      cfg_subset = 1'b0;
      cfg_mask   = '1;
      reps_due.delete();
      fails      = 0;
      waiting    = 0;
      checked    = 0;
      reported   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (sor_reg_t'(paddr[4:3]))
          REG_SYM_COUNT:   cfg_count = pwdata[CNT_W-1:0];
          REG_USE_SUBSET:  cfg_subset = pwdata[0];
          REG_SUBSET_MASK: cfg_mask = pwdata[MASK_W-1:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        if (item.command == CMD_WRITE) begin
          site_map[item.perm_index][item.site_index] = item.target_site;
        end else begin
          reps_due.insert(reps_due.size(), reduce_orbit(item.state_bits));
        end
      end
      if (result.valid && result.ready) begin
        got = '{rep_state: result.rep_state, rep_perm: result.rep_perm,
                tie_mask: result.tie_mask, tie_count: result.tie_count,
                empty_search: result.empty_search};
        if (reps_due.size() == 0) begin
          fails++;
          if (reported < 10) begin
            reported++;
            $display("unexpected result: state %h perm %0d ties %h count %0d empty %b",
                     got.rep_state, got.rep_perm, got.tie_mask, got.tie_count,
                     got.empty_search);
          end
        end else begin
          want = reps_due.pop_front();
          checked++;
          if (got !== want) begin
            fails++;
            if (reported < 10) begin
              reported++;
              $display("result %0d mismatch at %0t", checked, $realtime);
              $display("  expected state %h perm %0d ties %h count %0d empty %b",
                       want.rep_state, want.rep_perm, want.tie_mask, want.tie_count,
                       want.empty_search);
              $display("  actual   state %h perm %0d ties %h count %0d empty %b",
                       got.rep_state, got.rep_perm, got.tie_mask, got.tie_count,
                       got.empty_search);
            end
          end
        end
      end
      waiting = reps_due.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// testbench top: stimulus, back-pressure and verdict for the symmetry orbit representative core
module tb;
  import sor_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SITES       = 32;
  localparam int MAX_PERMS   = 64;
  localparam int DRAIN       = MAX_PERMS + 10;
  localparam int LIMIT       = 1_000_000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 75;
  localparam int LONG_HOLD   = 300;
  // permutations with a full table: 0 to LOW_PERMS-1 and the top LOADED-LOW_PERMS (60 to 63)
  localparam int LOADED      = 16;
  localparam int LOW_PERMS   = 12;
  localparam logic [MASK_W-1:0] LOADED_MASK = 64'hf000_0000_0000_0fff;

  typedef enum {
    MAP_IDENTITY, MAP_SHIFT, MAP_MIRROR, MAP_SHUFFLE, MAP_COPY, MAP_SCATTER
  } map_kind_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  int                fail_count;
  int                pending;
  int                checked;
  int                cycles = 0;
  int                writes_sent = 0;
  int                settings_used = 0;
  bit                send_gaps = 1'b0;
  bit                take_gaps = 1'b0;
  bit                long_hold = 1'b0;
  logic [SITE_W-1:0] loaded [MAX_PERMS][SITES];

  sor_in_if  item_ch ();
  sor_out_if result_ch ();

  symmetry_orbit_representative_core #(
    .SITES     (SITES),
    .MAX_PERMS (MAX_PERMS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  orbit_rep_checker chk (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .fails   (fail_count),
    .waiting (pending),
    .checked (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input sor_cmd_t cmd, input logic [PERM_W-1:0] p,
                           input logic [SITE_W-1:0] s, input logic [SITE_W-1:0] t,
                           input logic [STATE_W-1:0] st);
    if (send_gaps && $urandom_range(0, 9) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.command     <= cmd;
    item_ch.perm_index  <= p;
    item_ch.site_index  <= s;
    item_ch.target_site <= t;
    item_ch.state_bits  <= st;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (cmd == CMD_WRITE) writes_sent++;
  endtask

  task automatic write_entry(input int p, input int s, input logic [SITE_W-1:0] t);
    send_item(CMD_WRITE, PERM_W'(p), SITE_W'(s), t, $urandom());
    loaded[p][s] = t;
  endtask

  task automatic query(input logic [STATE_W-1:0] st);
    send_item(CMD_QUERY, PERM_W'($urandom_range(0, 63)), SITE_W'($urandom_range(0, 31)),
              SITE_W'($urandom_range(0, 31)), st);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_reg(input sor_reg_t r, input logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CNT_W-1:0] cnt, input logic sub,
                           input logic [MASK_W-1:0] mask);
    settle();
    set_reg(REG_SYM_COUNT, APB_DW'(cnt));
    set_reg(REG_USE_SUBSET, APB_DW'(sub));
    set_reg(REG_SUBSET_MASK, mask);
    settings_used++;
  endtask

  function automatic int loaded_perm(input int n);
    return (n < LOW_PERMS) ? n : MAX_PERMS - LOADED + n;
  endfunction

  task automatic load_perm(input int k, input int prior);
    logic [SITE_W-1:0] map [SITES];
    int                order [SITES];
    map_kind_t         kind;
    int                shift, src, i, j, tmp;
    logic [SITE_W-1:0] sw;
    kind  = (prior == 0) ? MAP_IDENTITY : map_kind_t'($urandom_range(0, 5));
    shift = $urandom_range(1, SITES - 1);
    src   = (prior == 0) ? 0 : loaded_perm($urandom_range(0, prior - 1));
    for (i = 0; i < SITES; i++) begin
      order[i] = i;
      case (kind)
        MAP_SHIFT:   map[i] = SITE_W'((i + shift) % SITES);
        MAP_MIRROR:  map[i] = SITE_W'(SITES - 1 - i);
        MAP_COPY:    map[i] = loaded[src][i];
        MAP_SCATTER: map[i] = SITE_W'($urandom_range(0, SITES - 1));
        default:     map[i] = SITE_W'(i);
      endcase
    end
    for (i = SITES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
      if (kind == MAP_SHUFFLE) begin
        j = $urandom_range(0, i);
        sw = map[i];
        map[i] = map[j];
        map[j] = sw;
      end
    end
    for (i = 0; i < SITES; i++) write_entry(k, order[i], map[order[i]]);
  endtask

  function automatic logic [STATE_W-1:0] random_state();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return STATE_W'(1) << $urandom_range(0, STATE_W - 1);
      3:       return $urandom() & $urandom() & $urandom();
      4:       return $urandom() | $urandom();
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] random_mask();
    case ($urandom_range(0, 4))
      0:       return '1;
      1:       return '0;
      2:       return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      3:       return {$urandom(), $urandom()} & {$urandom(), $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] random_count();
    case ($urandom_range(0, 3))
      0:       return CNT_W'(MAX_PERMS);
      1:       return CNT_W'($urandom_range(0, 127));
      default: return CNT_W'($urandom_range(1, MAX_PERMS));
    endcase
  endfunction

  initial begin : result_taker
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (take_gaps && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int   ph, n;
    logic sub;
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.command     <= CMD_WRITE;
    item_ch.perm_index  <= '0;
    item_ch.site_index  <= '0;
    item_ch.target_site <= '0;
    item_ch.state_bits  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: only permutation 0 searched
    load_perm(0, 0);
    query('0);
    query('1);
    query($urandom());
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    for (n = 1; n < LOADED; n++) load_perm(loaded_perm(n), n);

    // searches only ever touch permutations with a full table
    configure(CNT_W'(LOW_PERMS), 1'b0, '1);
    query('0);
    query('1);
    query(32'h0000_0001);
    query(32'h8000_0000);
    query($urandom());
    write_entry(0, 0, SITE_W'(SITES - 1));
    query(32'h0000_0001);
    configure(CNT_W'(MAX_PERMS), 1'b1, LOADED_MASK);
    write_entry(MAX_PERMS - 1, SITES - 1, '0);
    query(32'h8000_0000);
    configure(CNT_W'(127), 1'b1, LOADED_MASK);
    query($urandom());
    query('0);
    configure('0, 1'b0, '1);
    query($urandom());
    configure(CNT_W'(MAX_PERMS), 1'b1, '0);
    query($urandom());
    configure(CNT_W'(MAX_PERMS), 1'b1, 64'h8000_0000_0000_0000);
    query($urandom());
    configure(CNT_W'(MAX_PERMS - 1), 1'b1, 64'h8000_0000_0000_0000);
    query($urandom());
    configure(CNT_W'(MAX_PERMS), 1'b1, 64'haaaa_aaaa_aaaa_aaaa & LOADED_MASK);
    query($urandom());
    query('0);
    configure(CNT_W'(MAX_PERMS), 1'b1, 64'h5555_5555_5555_5555 & LOADED_MASK);
    query($urandom());

    for (ph = 0; ph < PHASES; ph++) begin
      sub = 1'($urandom_range(0, 1));
      configure(sub ? random_count() : CNT_W'($urandom_range(0, LOW_PERMS)), sub,
                random_mask() & LOADED_MASK);
      send_gaps = (ph < PHASES - 2) && (ph % 3 != 2);
      take_gaps = (ph < PHASES - 2) && (ph % 4 != 3);
      if (ph == 4) begin
        send_gaps = 1'b0;
        long_hold = 1'b1;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 6 && n == PHASE_ITEMS / 2) begin
          item_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        if ($urandom_range(0, 6) == 0) begin
          write_entry($urandom_range(0, MAX_PERMS - 1), $urandom_range(0, SITES - 1),
                      SITE_W'($urandom_range(0, SITES - 1)));
        end else begin
          query(random_state());
        end
      end
    end

    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("checked %0d results after %0d table writes over %0d register settings",
             checked, writes_sent, settings_used);
    $display("with a %0d-cycle result hold-off and a pause to drain mid-phase", LONG_HOLD);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
